>>> rtl/sts_pkg.sv
package sts_pkg;

  // Number of equal linear segments over the tanh argument range [0, 8].
  localparam int TABLE_SEGMENTS = 64;

  // Table index width: it must also hold TABLE_SEGMENTS itself.
  localparam int IDX_W = $clog2(TABLE_SEGMENTS + 1);

  // The argument is Q.16 and limited to 8.0, so the segment position carries a
  // 19-bit remainder below the index.
  localparam int FRAC_W = 19;
  localparam int POS_W  = FRAC_W + IDX_W;

  // Tanh argument limit of plus or minus 8.0 in Q.16.
  localparam logic signed [32:0] ARG_MAX = 33'sd524288;
  localparam logic signed [32:0] ARG_MIN = -33'sd524288;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_THRESHOLD      = 2'd0,
    REG_SLOPE_GAIN     = 2'd1,
    REG_PEAK_AMPLITUDE = 2'd2
  } cfg_reg_e;

  // Configuration register set as seen by the datapath.
  typedef struct packed {
    logic signed [15:0] threshold;
    logic signed [15:0] slope_gain;
    logic signed [15:0] peak_amplitude;
  } cfg_t;

  // Breakpoint table of tanh in Q1.15, one entry per segment end.
  typedef logic [TABLE_SEGMENTS:0][15:0] lut_t;

  // Unsigned quotient by shift and subtract; only used while the table is built.
  function automatic longint udiv_u64(longint num, longint den);
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] q;
    logic [64:0] r;
    n = num;
    d = den;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return longint'(q);
  endfunction

  // Builds the breakpoints at elaboration time. Entry i is tanh(8*i/SEGMENTS),
  // taken from exp(-2x) in Q.30: whole powers of exp(-1) by repeated
  // multiplication and the fractional part by a Taylor series to degree 24.
  function automatic lut_t build_tanh_lut();
    lut_t  lut;
    longint q30_one;
    longint exp_neg1;
    longint num;
    longint whole;
    longint rest;
    longint f;
    longint e;
    longint term;
    longint sum;
    longint t;
    q30_one  = 64'sd1 <<< 30;
    exp_neg1 = 64'sd395007542;
    for (int i = 0; i <= TABLE_SEGMENTS; i++) begin
      num   = 64'sd16 * longint'(i);
      whole = num / TABLE_SEGMENTS;
      rest  = num % TABLE_SEGMENTS;
      f     = (rest <<< 30) / TABLE_SEGMENTS;
      sum   = q30_one;
      term  = q30_one;
      for (int k = 1; k <= 24; k++) begin
        term = udiv_u64((term * f) >>> 30, longint'(k));
        if ((k % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      e = sum;
      for (longint n = 0; n < whole; n++) begin
        e = (e * exp_neg1) >>> 30;
      end
      t = udiv_u64(((q30_one - e) <<< 15) + ((q30_one + e) >>> 1), q30_one + e);
      if (t > 64'sd32767) begin
        t = 64'sd32767;
      end
      if (t < 64'sd0) begin
        t = 64'sd0;
      end
      lut[i] = t[15:0];
    end
    return lut;
  endfunction

  localparam lut_t TANH_LUT = build_tanh_lut();

endpackage

>>> rtl/sts_cfg_regs.sv
module sts_cfg_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  output sts_pkg::cfg_t        cfg_o
);

  sts_pkg::cfg_t cfg_q;
  sts_pkg::cfg_t cfg_d;

  // Registers take a write in any cycle.
  assign cfg_ready_o = 1'b1;

  // Decode the register index; writes to unused indexes are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (sts_pkg::cfg_reg_e'(cfg_index_i))
        sts_pkg::REG_THRESHOLD:      cfg_d.threshold      = cfg_data_i;
        sts_pkg::REG_SLOPE_GAIN:     cfg_d.slope_gain     = cfg_data_i;
        sts_pkg::REG_PEAK_AMPLITUDE: cfg_d.peak_amplitude = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Register file with its reset values: no offset, unity gain and amplitude.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold      <= 16'sd0;
      cfg_q.slope_gain     <= 16'sd256;
      cfg_q.peak_amplitude <= 16'sd256;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/sts_arg_front.sv
module sts_arg_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [15:0]   sample_i,
  input  logic signed [15:0]   threshold_i,
  input  logic signed [15:0]   slope_gain_i,
  output logic                 valid_o,
  output logic signed [32:0]   arg_o
);

  logic                valid1_q;
  logic                valid2_q;
  logic signed [16:0]  diff_q;
  logic signed [16:0]  diff_d;
  logic signed [32:0]  arg_q;
  logic signed [32:0]  arg_d;

  // Stage 1: remove the threshold, exact in 17 bits.
  assign diff_d = 17'(sample_i) - 17'(threshold_i);

  // Stage 2: apply the gain, exact Q.16 product.
  assign arg_d = slope_gain_i * diff_q;

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  // Data registers.
  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    arg_q  <= arg_d;
  end

  assign valid_o = valid2_q;
  assign arg_o   = arg_q;

endmodule

>>> rtl/sts_tanh_unit.sv
module sts_tanh_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [32:0]   arg_i,
  output logic                 valid_o,
  output logic signed [16:0]   tanh_o
);

  localparam int IDX_W  = sts_pkg::IDX_W;
  localparam int FRAC_W = sts_pkg::FRAC_W;
  localparam int POS_W  = sts_pkg::POS_W;

  logic                    valid3_q;
  logic                    valid4_q;
  logic                    valid5_q;

  logic signed [32:0]      arg_sat;
  logic signed [32:0]      arg_abs;
  logic [POS_W-1:0]        pos;

  logic [IDX_W-1:0]        idx_q;
  logic [FRAC_W-1:0]       frac3_q;
  logic                    neg3_q;

  logic [IDX_W-1:0]        idx_next;
  logic [15:0]             t0_d;
  logic signed [16:0]      dt_d;
  logic [15:0]             t0_q;
  logic signed [16:0]      dt_q;
  logic [FRAC_W-1:0]       frac4_q;
  logic                    neg4_q;

  logic signed [36:0]      step_prod;
  logic signed [36:0]      step_rnd;
  logic [16:0]             interp;
  logic signed [16:0]      tanh_d;
  logic signed [16:0]      tanh_q;

  // Stage 3: limit the argument to plus or minus 8, fold the sign and find
  // the segment and the position inside it.
  always_comb begin
    if (arg_i > sts_pkg::ARG_MAX) begin
      arg_sat = sts_pkg::ARG_MAX;
    end else if (arg_i < sts_pkg::ARG_MIN) begin
      arg_sat = sts_pkg::ARG_MIN;
    end else begin
      arg_sat = arg_i;
    end
    arg_abs = arg_sat[32] ? -arg_sat : arg_sat;
    pos     = POS_W'(arg_abs[19:0]) * POS_W'(sts_pkg::TABLE_SEGMENTS);
  end

  // Stage 4: read both segment ends; at the very end of the range the last
  // breakpoint stands alone.
  always_comb begin
    idx_next = idx_q + IDX_W'(1);
    if (idx_q >= IDX_W'(sts_pkg::TABLE_SEGMENTS)) begin
      t0_d = sts_pkg::TANH_LUT[sts_pkg::TABLE_SEGMENTS];
      dt_d = 17'sd0;
    end else begin
      t0_d = sts_pkg::TANH_LUT[idx_q];
      dt_d = $signed({1'b0, sts_pkg::TANH_LUT[idx_next]})
           - $signed({1'b0, t0_d});
    end
  end

  // Stage 5: linear interpolation rounded half up, then restore the sign.
  always_comb begin
    step_prod = dt_q * $signed({1'b0, frac4_q});
    step_rnd  = step_prod + 37'sd262144;
    interp    = {1'b0, t0_q} + step_rnd[35:19];
    tanh_d    = neg4_q ? -$signed(interp) : $signed(interp);
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
      valid5_q <= 1'b0;
    end else begin
      valid3_q <= valid_i;
      valid4_q <= valid3_q;
      valid5_q <= valid4_q;
    end
  end

  // Data registers.
  always_ff @(posedge clk_i) begin
    idx_q   <= pos[POS_W-1:FRAC_W];
    frac3_q <= pos[FRAC_W-1:0];
    neg3_q  <= arg_sat[32];
    t0_q    <= t0_d;
    dt_q    <= dt_d;
    frac4_q <= frac3_q;
    neg4_q  <= neg3_q;
    tanh_q  <= tanh_d;
  end

  assign valid_o = valid5_q;
  assign tanh_o  = tanh_q;

endmodule

>>> rtl/sts_out_scale.sv
module sts_out_scale (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [16:0]   tanh_i,
  input  logic signed [15:0]   peak_amplitude_i,
  output logic                 valid_o,
  output logic signed [15:0]   result_o
);

  logic                valid6_q;
  logic                valid7_q;
  logic signed [17:0]  sig;
  logic signed [33:0]  prod_d;
  logic signed [33:0]  prod_q;
  logic signed [34:0]  rnd;
  logic signed [18:0]  y;
  logic signed [15:0]  result_d;
  logic signed [15:0]  result_q;

  // Stage 6: sigmoid in Q.16 times the amplitude.
  assign sig    = 18'(tanh_i) + 18'sd32768;
  assign prod_d = peak_amplitude_i * sig;

  // Stage 7: round half up toward Q8.8 and saturate to 16 bits.
  always_comb begin
    rnd = 35'(prod_q) + 35'sd32768;
    y   = rnd[34:16];
    if (y > 19'sd32767) begin
      result_d = 16'sd32767;
    end else if (y < -19'sd32768) begin
      result_d = -16'sd32768;
    end else begin
      result_d = y[15:0];
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid6_q <= 1'b0;
      valid7_q <= 1'b0;
    end else begin
      valid6_q <= valid_i;
      valid7_q <= valid6_q;
    end
  end

  // Data registers.
  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    result_q <= result_d;
  end

  assign valid_o  = valid7_q;
  assign result_o = result_q;

endmodule

>>> rtl/scaled_tanh_sigmoid.sv
// Scaled tanh sigmoid: each sample gives
// peak_amplitude * (tanh(slope_gain * (sample_in - threshold)) + 1) / 2, all
// in signed Q8.8, with tanh from a piecewise-linear table and the tanh
// argument limited to plus or minus 8. The block takes a sample in every
// cycle (busy stays low) and shows its result on activation_out_o with a
// one-cycle done_o strobe; results come out in input order. The result passes
// through seven register stages (offset, gain multiply, segment search, table
// read, interpolation, amplitude multiply, rounding). There is no output
// buffer and the receiver cannot stall, so it must take every done_o beat as
// it comes. Write the configuration registers only when no sample is in
// flight.
module scaled_tanh_sigmoid (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [15:0]   sample_in_i,
  output logic                 done_o,
  output logic signed [15:0]   activation_out_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  sts_pkg::cfg_t       cfg;
  logic                in_beat;
  logic                arg_valid;
  logic signed [32:0]  arg;
  logic                tanh_valid;
  logic signed [16:0]  tanh_val;

  // The pipeline never blocks, so a sample is taken whenever start is high.
  assign busy    = 1'b0;
  assign in_beat = start && !busy;

  // Configuration registers.
  sts_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Offset and gain.
  sts_arg_front u_arg_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_beat),
    .sample_i     (sample_in_i),
    .threshold_i  (cfg.threshold),
    .slope_gain_i (cfg.slope_gain),
    .valid_o      (arg_valid),
    .arg_o        (arg)
  );

  // Table based tanh.
  sts_tanh_unit u_tanh_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (arg_valid),
    .arg_i   (arg),
    .valid_o (tanh_valid),
    .tanh_o  (tanh_val)
  );

  // Sigmoid scaling and output register.
  sts_out_scale u_out_scale (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (tanh_valid),
    .tanh_i           (tanh_val),
    .peak_amplitude_i (cfg.peak_amplitude),
    .valid_o          (done_o),
    .result_o         (activation_out_o)
  );

  // Every accepted sample yields a result on done_o.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |-> ##7 done_o)
    else $error("accepted sample produced no result");

  // No result appears without a matching sample taken before it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_beat, 7))
    else $error("result without matching sample");

endmodule
